>>> src/trd_pkg.sv
// Package for the TLV receive deframer: item and result types, phase and
// role codes, status codes and default constants. No dependencies.
package trd_pkg;

    localparam int ROUTE_BYTES_DEF = 4;
    localparam int HDR_BASE_BYTES  = 2;
    localparam int BYTE_MAX        = 8'hff;

    typedef enum logic [2:0] {
        PH_READY  = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_VALUE  = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_ROUTE   = 3'd0,
        ROLE_TYPE    = 3'd1,
        ROLE_LENGTH  = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_DISCARD = 3'd4
    } t_role;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FRAME  = 3'd1,
        ST_PARITY = 3'd2,
        ST_OVERRUN = 3'd3,
        ST_DROP   = 3'd4,
        ST_LENGTH = 3'd5
    } t_status;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic       frame_error;
        logic       parity_error;
        logic       overrun_error;
        logic       drop_error;
    } t_item;

    typedef struct packed {
        logic [7:0] byte_out;
        t_role      byte_role;
        logic [7:0] message_type;
        logic       last_of_message;
        t_status    status;
    } t_result;

endpackage

>>> src/tlv_receive_deframer_core.sv
// Top level of the TLV receive deframer: input/output channels, config
// register, output register with skid stage. Uses trd_pkg and trd_parser.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one received byte with its
//   line error flags, or a restart (i_kind = 1). A transaction is taken when
//   valid is high and stall is low. Every input gives exactly one result on the
//   output channel (o_out_valid / i_out_stall), taken when valid is high and
//   stall is low.
//   The result of a taken item is registered in the output register, or in the
//   skid register when the output stalls. Throughput is one item per cycle while
//   o_in_stall is low, set by the single parse stage before the output register.
//   When the receiver stalls, one more result is caught in a skid register and
//   o_in_stall rises the cycle after; it drops once the skid entry drains.
//   The config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   routing header mode bit; ready is always high.
//   Synchronous reset (i_rst_n low) returns the parser to the ready phase, clears
//   the error and the mode bit, and empties the output and skid registers.
module tlv_receive_deframer_core #(
    parameter int P_ROUTE_BYTES = trd_pkg::ROUTE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_error,
    input  logic       i_parity_error,
    input  logic       i_overrun_error,
    input  logic       i_drop_error,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_role,
    output logic [7:0] o_message_type,
    output logic       o_last_of_message,
    output logic [2:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import trd_pkg::*;

    t_item   item;
    t_result result;
    logic    in_fire;
    logic    out_fire;
    logic    r_route_mode;

    t_result r_out,  n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_skid, n_skid;
    logic    r_skid_valid, n_skid_valid;

    assign item.kind          = i_kind;
    assign item.rx_byte       = i_rx_byte;
    assign item.frame_error   = i_frame_error;
    assign item.parity_error  = i_parity_error;
    assign item.overrun_error = i_overrun_error;
    assign item.drop_error    = i_drop_error;

    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    trd_parser #(
        .P_ROUTE_BYTES(P_ROUTE_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_item       (item),
        .i_route_mode (r_route_mode),
        .o_result     (result)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = result;
                n_out_valid = in_fire;
            end
        end else if (in_fire) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_route_mode <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_route_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_out        = r_out.byte_out;
    assign o_byte_role       = r_out.byte_role;
    assign o_message_type    = r_out.message_type;
    assign o_last_of_message = r_out.last_of_message;
    assign o_status          = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result lost while output stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_fire) |=> (r_out_valid && !r_skid_valid
            && r_out == $past(r_skid)))
        else $error("skid entry not moved to output");

endmodule

>>> src/trd_parser.sv
// TLV parser: phase state and counters, one transaction per cycle.
// Produces the result for the current item combinationally. Uses trd_pkg.
module trd_parser #(
    parameter int P_ROUTE_BYTES = trd_pkg::ROUTE_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  trd_pkg::t_item   i_item,
    input  logic             i_route_mode,
    output trd_pkg::t_result o_result
);
    import trd_pkg::*;

    localparam int CW = $clog2(P_ROUTE_BYTES + 1);
    localparam logic [7:0] MAX_LEN_PLAIN = 8'(BYTE_MAX - HDR_BASE_BYTES);
    localparam logic [7:0] MAX_LEN_ROUTE = 8'(BYTE_MAX - HDR_BASE_BYTES - P_ROUTE_BYTES);

    t_phase      r_phase,  n_phase;
    logic [CW-1:0] r_hcnt, n_hcnt;
    logic [7:0]  r_remain, n_remain;
    logic [7:0]  r_type,   n_type;
    t_status     r_err,    n_err;

    t_status     line_err;
    logic [CW-1:0] hcnt_inc;
    logic [7:0]  max_len;
    logic [7:0]  remain_dec;

    always_comb begin
        if (i_item.frame_error) begin
            line_err = ST_FRAME;
        end else if (i_item.parity_error) begin
            line_err = ST_PARITY;
        end else if (i_item.overrun_error) begin
            line_err = ST_OVERRUN;
        end else if (i_item.drop_error) begin
            line_err = ST_DROP;
        end else begin
            line_err = ST_OK;
        end
    end

    assign hcnt_inc   = r_hcnt + 1'b1;
    assign max_len    = i_route_mode ? MAX_LEN_ROUTE : MAX_LEN_PLAIN;
    assign remain_dec = r_remain - 8'd1;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_remain = r_remain;
        n_type   = r_type;
        n_err    = r_err;
        if (i_item.kind == KIND_RESTART) begin
            n_phase  = PH_READY;
            n_hcnt   = '0;
            n_remain = '0;
            n_type   = '0;
            n_err    = ST_OK;
        end else if (r_phase == PH_ERROR) begin
            n_phase = PH_ERROR;
        end else if (line_err != ST_OK) begin
            n_err   = line_err;
            n_phase = PH_ERROR;
        end else begin
            case (r_phase)
                PH_READY: begin
                    if (i_route_mode) begin
                        if (hcnt_inc >= CW'(P_ROUTE_BYTES)) begin
                            n_hcnt  = '0;
                            n_phase = PH_TYPE;
                        end else begin
                            n_hcnt = hcnt_inc;
                        end
                    end else begin
                        n_hcnt  = '0;
                        n_type  = i_item.rx_byte;
                        n_phase = PH_LENGTH;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_item.rx_byte;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (i_item.rx_byte > max_len) begin
                        n_err   = ST_LENGTH;
                        n_phase = PH_ERROR;
                    end else if (i_item.rx_byte == 8'd0) begin
                        n_remain = '0;
                        n_phase  = PH_READY;
                    end else begin
                        n_remain = i_item.rx_byte;
                        n_phase  = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    n_remain = remain_dec;
                    if (remain_dec == 8'd0) begin
                        n_phase = PH_READY;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_result.byte_out        = i_item.rx_byte;
        o_result.byte_role       = ROLE_DISCARD;
        o_result.message_type    = '0;
        o_result.last_of_message = 1'b0;
        o_result.status          = ST_OK;
        if (i_item.kind == KIND_RESTART) begin
            o_result.byte_out = '0;
        end else if (r_phase == PH_ERROR) begin
            o_result.status = r_err;
        end else if (line_err != ST_OK) begin
            o_result.status = line_err;
        end else begin
            case (r_phase)
                PH_READY: begin
                    if (i_route_mode) begin
                        o_result.byte_role = ROLE_ROUTE;
                    end else begin
                        o_result.byte_role    = ROLE_TYPE;
                        o_result.message_type = i_item.rx_byte;
                    end
                end
                PH_TYPE: begin
                    o_result.byte_role    = ROLE_TYPE;
                    o_result.message_type = i_item.rx_byte;
                end
                PH_LENGTH: begin
                    o_result.byte_role    = ROLE_LENGTH;
                    o_result.message_type = r_type;
                    if (i_item.rx_byte > max_len) begin
                        o_result.status = ST_LENGTH;
                    end else if (i_item.rx_byte == 8'd0) begin
                        o_result.last_of_message = 1'b1;
                    end
                end
                PH_VALUE: begin
                    o_result.byte_role       = ROLE_VALUE;
                    o_result.message_type    = r_type;
                    o_result.last_of_message = (remain_dec == 8'd0);
                end
                default: begin
                    o_result.status = r_err;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_READY;
            r_hcnt   <= '0;
            r_remain <= '0;
            r_type   <= '0;
            r_err    <= ST_OK;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_remain <= n_remain;
            r_type   <= n_type;
            r_err    <= n_err;
        end
    end

    a_err_code_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> (r_err != ST_OK))
        else $error("error phase without error code");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_remain != 8'd0))
        else $error("value phase with no bytes remaining");

    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt < CW'(P_ROUTE_BYTES)) && ((r_phase == PH_READY) || (r_hcnt == '0)))
        else $error("routing header count out of range");

endmodule

>>> verif/deframe_check_pkg.sv
// Scoreboard class for the TLV receive deframer testbench: tracks the parse
// state, predicts the tagged byte for each input transaction and checks results.
// Depends on trd_pkg.
package deframe_check_pkg;
    import trd_pkg::*;

    class deframe_checker;
        int unsigned route_len;
        bit          route_mode;
        t_phase      stage;
        logic [3:0]  route_seen;
        logic [7:0]  values_left;
        logic [7:0]  msg_type;
        t_status     held_code;
        t_result     expected_bytes[$];
        int unsigned mismatches;

        function new(int unsigned n_route);
            route_len  = n_route;
            route_mode = 1'b0;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            stage       = PH_READY;
            route_seen  = '0;
            values_left = '0;
            msg_type    = '0;
            held_code   = ST_OK;
        endfunction

        function void set_mode(bit m);
            route_mode = m;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function void report(string msg);
            if (mismatches < 100) begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
            mismatches++;
        endfunction

        function void take_item(t_item it);
            t_result     r;
            t_status     flag;
            int unsigned max_len;
            r.byte_out        = it.rx_byte;
            r.byte_role       = ROLE_DISCARD;
            r.message_type    = '0;
            r.last_of_message = 1'b0;
            r.status          = ST_OK;
            if (it.frame_error) begin
                flag = ST_FRAME;
            end else if (it.parity_error) begin
                flag = ST_PARITY;
            end else if (it.overrun_error) begin
                flag = ST_OVERRUN;
            end else if (it.drop_error) begin
                flag = ST_DROP;
            end else begin
                flag = ST_OK;
            end

            if (it.kind == KIND_RESTART) begin
                clear();
                r.byte_out = '0;
            end else if (stage == PH_ERROR) begin
                r.status = held_code;
            end else if (flag != ST_OK) begin
                held_code = flag;
                stage     = PH_ERROR;
                r.status  = flag;
            end else begin
                case (stage)
                    PH_READY, PH_TYPE: begin
                        if (stage == PH_READY && route_mode) begin
                            r.byte_role = ROLE_ROUTE;
                            route_seen++;
                            if (route_seen >= route_len) begin
                                route_seen = '0;
                                stage      = PH_TYPE;
                            end
                        end else begin
                            route_seen     = '0;
                            msg_type       = it.rx_byte;
                            stage          = PH_LENGTH;
                            r.byte_role    = ROLE_TYPE;
                            r.message_type = it.rx_byte;
                        end
                    end
                    PH_LENGTH: begin
                        r.byte_role    = ROLE_LENGTH;
                        r.message_type = msg_type;
                        max_len = BYTE_MAX - HDR_BASE_BYTES - (route_mode ? route_len : 0);
                        if (it.rx_byte > max_len) begin
                            held_code = ST_LENGTH;
                            stage     = PH_ERROR;
                            r.status  = ST_LENGTH;
                        end else if (it.rx_byte == 0) begin
                            r.last_of_message = 1'b1;
                            stage             = PH_READY;
                            values_left       = '0;
                        end else begin
                            values_left = it.rx_byte;
                            stage       = PH_VALUE;
                        end
                    end
                    default: begin
                        r.byte_role    = ROLE_VALUE;
                        r.message_type = msg_type;
                        if (values_left != 0) values_left--;
                        if (values_left == 0) begin
                            r.last_of_message = 1'b1;
                            stage             = PH_READY;
                        end
                    end
                endcase
            end
            expected_bytes.push_back(r);
        endfunction

        function void cmp_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report($sformatf("%s got %02h want %02h", name, got, want));
            end
        endfunction

        function void check_byte(logic [7:0] b, logic [2:0] role, logic [7:0] mtype,
                                 logic last, logic [2:0] st);
            t_result want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("result %02h with nothing expected", b));
                return;
            end
            want = expected_bytes.pop_front();
            cmp_field("byte_out", b, want.byte_out);
            cmp_field("byte_role", 8'(role), 8'(want.byte_role));
            cmp_field("message_type", mtype, want.message_type);
            cmp_field("last_of_message", 8'(last), 8'(want.last_of_message));
            cmp_field("status", 8'(st), 8'(want.status));
        endfunction
    endclass

endpackage

>>> verif/tb_top.sv
// Testbench top for tlv_receive_deframer_core: drives directed and random
// byte streams with random stalls, checks every result via deframe_check_pkg.
// Depends on trd_pkg, deframe_check_pkg and the deframer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import trd_pkg::*;
    import deframe_check_pkg::*;

    localparam int ROUTE_BYTES = ROUTE_BYTES_DEF;
    localparam int TOTAL_ITEMS = 1800;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_LIMIT  = 2000;

    localparam logic [3:0] FL_NONE    = 4'b0000;
    localparam logic [3:0] FL_FRAME   = 4'b1000;
    localparam logic [3:0] FL_PARITY  = 4'b0100;
    localparam logic [3:0] FL_OVERRUN = 4'b0010;
    localparam logic [3:0] FL_DROP    = 4'b0001;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_kind;
    logic [7:0] i_rx_byte;
    logic       i_frame_error;
    logic       i_parity_error;
    logic       i_overrun_error;
    logic       i_drop_error;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_byte_out;
    logic [2:0] o_byte_role;
    logic [7:0] o_message_type;
    logic       o_last_of_message;
    logic [2:0] o_status;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    tlv_receive_deframer_core #(.P_ROUTE_BYTES(ROUTE_BYTES)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .i_frame_error    (i_frame_error),
        .i_parity_error   (i_parity_error),
        .i_overrun_error  (i_overrun_error),
        .i_drop_error     (i_drop_error),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_byte_out       (o_byte_out),
        .o_byte_role      (o_byte_role),
        .o_message_type   (o_message_type),
        .o_last_of_message(o_last_of_message),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    deframe_checker chk;
    bit             burst;
    bit             hold_req;
    bit             mode_now;
    int unsigned    items_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_item data_item(logic [7:0] b, logic [3:0] flags);
        t_item it;
        it.kind          = KIND_BYTE;
        it.rx_byte       = b;
        it.frame_error   = flags[3];
        it.parity_error  = flags[2];
        it.overrun_error = flags[1];
        it.drop_error    = flags[0];
        return it;
    endfunction

    function automatic t_item restart_item();
        t_item it;
        it      = data_item(rand_byte(), 4'($urandom_range(0, 15)));
        it.kind = KIND_RESTART;
        return it;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it = data_item(rand_byte(), ($urandom_range(0, 3) == 0) ?
                       4'($urandom_range(0, 15)) : FL_NONE);
        if ($urandom_range(0, 9) == 0) it.kind = KIND_RESTART;
        return it;
    endfunction

    task automatic send(input t_item it);
        int unsigned n;
        i_in_valid      <= 1'b1;
        i_kind          <= it.kind;
        i_rx_byte       <= it.rx_byte;
        i_frame_error   <= it.frame_error;
        i_parity_error  <= it.parity_error;
        i_overrun_error <= it.overrun_error;
        i_drop_error    <= it.drop_error;
        do @(posedge i_clk); while (o_in_stall);
        chk.take_item(it);
        items_sent++;
        n = gap_len();
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [3:0] flags);
        send(data_item(b, flags));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        drain();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.set_mode(m);
        mode_now = m;
        i_cfg_valid <= 1'b0;
    endtask

    // one message, mostly well formed; some get a line error, a bad length or
    // an early cut, and those are followed by noise and a restart
    task automatic send_message(input bit partial);
        t_item       msg[$];
        int unsigned len;
        int unsigned limit;
        int unsigned cut;
        int unsigned pick;
        int unsigned keep;
        bit          broken;
        limit = BYTE_MAX - HDR_BASE_BYTES - (mode_now ? ROUTE_BYTES : 0);
        if (mode_now) repeat (ROUTE_BYTES) msg.push_back(data_item(rand_byte(), FL_NONE));
        msg.push_back(data_item(rand_byte(), FL_NONE));
        pick = $urandom_range(0, 99);
        if (pick < 40) len = $urandom_range(0, 4);
        else if (pick < 80) len = $urandom_range(5, 16);
        else if (pick < 92) len = $urandom_range(17, 64);
        else if (pick < 95) len = limit;
        else len = $urandom_range(limit + 1, 255);
        msg.push_back(data_item(len[7:0], FL_NONE));
        if (len <= limit) repeat (len) msg.push_back(data_item(rand_byte(), FL_NONE));
        broken = (len > limit);

        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            cut = $urandom_range(0, msg.size() - 1);
            while (msg.size() > cut + 1) void'(msg.pop_back());
            if (pick < 8) msg[cut] = data_item(msg[cut].rx_byte, 4'($urandom_range(1, 15)));
            broken = 1'b1;
        end
        if (broken) begin
            repeat ($urandom_range(0, 3)) msg.push_back(noise_item());
            msg.push_back(restart_item());
        end

        keep = partial ? $urandom_range(1, msg.size() - 1) : msg.size();
        for (int unsigned k = 0; k < keep; k++) send(msg[k]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chk.check_byte(o_byte_out, o_byte_role, o_message_type, o_last_of_message,
                           o_status);
        end
    end

    initial begin
        int unsigned n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = gap_len();
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, burst ? 40 : 6)) @(posedge i_clk);
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned next_phase;
        int unsigned phase_no;
        chk        = new(ROUTE_BYTES);
        burst      = 1'b0;
        hold_req   = 1'b0;
        mode_now   = 1'b0;
        items_sent = 0;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_kind          <= KIND_BYTE;
        i_rx_byte       <= '0;
        i_frame_error   <= 1'b0;
        i_parity_error  <= 1'b0;
        i_overrun_error <= 1'b0;
        i_drop_error    <= 1'b0;
        i_out_stall     <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        write_mode(1'b0);
        send_byte(8'h00, FL_NONE);
        send_byte(8'h00, FL_NONE);
        send_byte(8'hff, FL_NONE);
        send_byte(8'h02, FL_NONE);
        send_byte(8'hff, FL_NONE);
        send_byte(8'h00, FL_NONE);
        send_byte(8'h5a, FL_NONE);
        send_byte(8'hfe, FL_NONE);
        send(restart_item());
        send_byte(8'hc3, FL_FRAME | FL_PARITY | FL_OVERRUN | FL_DROP);
        send_byte(8'h3c, FL_PARITY);
        send(restart_item());
        send_byte(8'h11, FL_PARITY | FL_OVERRUN | FL_DROP);
        send(restart_item());
        send_byte(8'h22, FL_OVERRUN | FL_DROP);
        send(restart_item());
        send_byte(8'h44, FL_DROP);
        send(restart_item());
        write_mode(1'b1);
        send_byte(8'h00, FL_NONE);
        send_byte(8'hff, FL_NONE);
        write_mode(1'b0);
        send_byte(8'h7e, FL_NONE);
        send_byte(8'h01, FL_NONE);
        send_byte(8'h80, FL_NONE);
        write_mode(1'b1);
        repeat (ROUTE_BYTES) send_byte(rand_byte(), FL_NONE);
        send_byte(8'h81, FL_NONE);
        send_byte(8'(BYTE_MAX - HDR_BASE_BYTES - ROUTE_BYTES + 1), FL_NONE);
        send(restart_item());

        // random
        phase_no   = 0;
        next_phase = items_sent + 250;
        while (items_sent < TOTAL_ITEMS) begin
            send_message(1'b0);
            if (items_sent >= next_phase) begin
                if ($urandom_range(0, 1) == 1) send_message(1'b1);
                phase_no++;
                burst = (phase_no % 3 == 1);
                write_mode((phase_no == 1) ? ~mode_now : 1'($urandom_range(0, 1)));
                if (phase_no == 2) begin
                    burst    = 1'b1;
                    hold_req = 1'b1;
                end
                next_phase = items_sent + 250;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (chk.pending() != 0) chk.report("results never arrived");
        if (chk.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
